FILE: sv/uvs_pkg.sv
// Shared types and constants of the UV sphere vertex generator.
`default_nettype none

package uvs_pkg;

  // Index and count width of the grid inputs and count registers
  localparam int IW = 11;
  // Divisor and remainder width: covers twice the largest ring count
  localparam int DW = IW + 1;
  // Phase width in units of 2^-32 turn
  localparam int PW = 32;
  // Quarter-wave argument and magnitude width (Q30 up to 1.0)
  localparam int XW = 31;
  // Horner accumulator width
  localparam int SW = 32;
  // Number of sine lanes: sin theta, cos theta, sin phi, cos phi
  localparam int NPH = 4;
  // Number of Horner steps after the first coefficient
  localparam int HN = 5;

  localparam logic [PW-1:0] Q30_ONE = 32'h4000_0000;
  localparam logic [XW-1:0] Q30_ONE_X = 31'h4000_0000;
  localparam logic [16:0] TEX_ONE = 17'h1_0000;
  localparam logic [15:0] NORM_MAX = 16'h7FFF;
  localparam logic [IW-1:0] SEG_MIN = 11'd3;
  localparam logic [IW-1:0] RING_MIN = 11'd2;

  // Q30 coefficients of the quarter-wave sine, highest order first
  localparam logic [SW-1:0] K11 = 32'd3864;
  localparam logic [SW-1:0] HCOEF [0:HN-1] = '{
    32'd172272, 32'd5026986, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_SEGMENTS = 2'd1,
    CFG_RINGS    = 2'd2
  } cfg_reg_t;

  // Grid point carried beside the datapath
  typedef struct packed {
    logic [IW-1:0] ring;
    logic [IW-1:0] seg;
  } grid_pt_t;

endpackage

`default_nettype wire

FILE: sv/uvs_div_cell.sv
// One restoring division step for several lanes, registered.
`default_nettype none

module uvs_div_cell
  import uvs_pkg::*;
#(
  parameter int LANES = 2,
  parameter int QW = 11
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [LANES-1:0][DW-1:0]       d_i,
  input  logic [LANES-1:0][DW-1:0]       rem_i,
  input  logic [LANES-1:0][QW-1:0]       feed_i,
  input  logic [LANES-1:0][QW-1:0]       q_i,
  output logic [LANES-1:0][DW-1:0]       rem_o,
  output logic [LANES-1:0][QW-1:0]       feed_o,
  output logic [LANES-1:0][QW-1:0]       q_o
);

  logic [LANES-1:0][DW:0]   part;
  logic [LANES-1:0]         ge;
  logic [LANES-1:0][DW-1:0] rem_nxt;
  logic [LANES-1:0][QW-1:0] feed_nxt;
  logic [LANES-1:0][QW-1:0] q_nxt;
  logic [LANES-1:0][DW-1:0] rem_r;
  logic [LANES-1:0][QW-1:0] feed_r;
  logic [LANES-1:0][QW-1:0] q_r;

  // Shift in the next numerator bit, subtract the divisor when it fits
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      part[l]     = {rem_i[l], feed_i[l][QW-1]};
      ge[l]       = part[l] >= {1'b0, d_i[l]};
      rem_nxt[l]  = ge[l] ? DW'(part[l] - {1'b0, d_i[l]}) : part[l][DW-1:0];
      feed_nxt[l] = {feed_i[l][QW-2:0], 1'b0};
      q_nxt[l]    = {q_i[l][QW-2:0], ge[l]};
    end
  end

  // Hand the partial result to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      feed_r <= feed_nxt;
      q_r    <= q_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign feed_o = feed_r;
  assign q_o    = q_r;

endmodule

`default_nettype wire

FILE: sv/uvs_horner_cell.sv
// One Horner step of the quarter-wave sine polynomial for all lanes.
`default_nettype none

module uvs_horner_cell
  import uvs_pkg::*;
#(
  parameter logic [SW-1:0] COEF = 32'd0
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [NPH-1:0][SW-1:0]   s_i,
  input  logic [NPH-1:0][XW-1:0]   y_i,
  input  logic [NPH-1:0][XW-1:0]   x_i,
  output logic [NPH-1:0][SW-1:0]   s_o,
  output logic [NPH-1:0][XW-1:0]   y_o,
  output logic [NPH-1:0][XW-1:0]   x_o
);

  logic [NPH-1:0][SW+XW-1:0] prod;
  logic [NPH-1:0][SW-1:0]    s_nxt;
  logic [NPH-1:0][SW-1:0]    s_r;
  logic [NPH-1:0][XW-1:0]    y_r;
  logic [NPH-1:0][XW-1:0]    x_r;

  // s <- coef - (s * y) >> 30
  always_comb begin
    for (int l = 0; l < NPH; l++) begin
      prod[l]  = {{XW{1'b0}}, s_i[l]} * {{SW{1'b0}}, y_i[l]};
      s_nxt[l] = COEF - prod[l][SW+29:30];
    end
  end

  // Register the step, carry x and y alongside
  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
      y_r <= y_i;
      x_r <= x_i;
    end
  end

  assign s_o = s_r;
  assign y_o = y_r;
  assign x_o = x_r;

endmodule

`default_nettype wire

FILE: sv/uv_sphere_vertex_generator_core.sv
// Top level of the UV sphere vertex generator: division chains, sine and output stages.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------
//  in_     | in  | in_tvalid / in_tready   | in_tdata: ring_index, segment_index
//  out_    | out | out_tvalid / out_tready | out_tdata: vertex data, tuser flags
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One grid point per cycle while the output is not stalled.
// The chain holds 11 modulo cells and 32 phase cells, then a quadrant fold,
// 7 multiply stages of the sine polynomial, direction products and scaling.
// All stages advance together; when the output holds a request that is not
// taken, the whole chain halts and in_tready drops.
// Reset clears the valid bits and loads radius 1.0, 16 segments, 8 rings.
`default_nettype none

module uv_sphere_vertex_generator_core
  import uvs_pkg::*;
#(
  parameter int MAX_SEGMENTS = 1024,
  parameter int MAX_RINGS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [10:0] ring_index, [21:11] segment_index, [23:22] zero
  input  logic [23:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [24:0] pos_x, [49:25] pos_y, [74:50] pos_z, [90:75] norm_x,
  // [106:91] norm_y, [122:107] norm_z, [139:123] tex_u, [156:140] tex_v,
  // [177:157] base_vertex, [198:178] below_vertex, [199] zero
  output logic [199:0] out_tdata,
  // [0] has_quad, [1] out_of_grid
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam int A_LEN = IW;
  localparam int B_LEN = PW;
  localparam int S_B_END = A_LEN + B_LEN;
  localparam int S_E0 = S_B_END + 1;
  localparam int S_E1 = S_E0 + 1;
  localparam int S_H_END = S_E1 + HN;
  localparam int S_E2 = S_H_END + 1;
  localparam int S_E3 = S_E2 + 1;
  localparam int LAT = S_E3 + 1;

  // Configuration registers
  logic [23:0]   radius_r;
  logic [IW-1:0] seg_cnt_r;
  logic [IW-1:0] ring_cnt_r;
  logic [IW-1:0] segs;
  logic [IW-1:0] rings;

  logic en;
  logic [LAT:1] vld_r;
  grid_pt_t in_pt;
  grid_pt_t rs_r [1:S_E3];

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 24'd65536;
      seg_cnt_r  <= 11'd16;
      ring_cnt_r <= 11'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS:   radius_r   <= cfg_data;
        CFG_SEGMENTS: seg_cnt_r  <= cfg_data[IW-1:0];
        CFG_RINGS:    ring_cnt_r <= cfg_data[IW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts into their legal ranges
  always_comb begin
    if (seg_cnt_r < SEG_MIN) segs = SEG_MIN;
    else if ({6'b0, seg_cnt_r} > 17'(MAX_SEGMENTS)) segs = IW'(MAX_SEGMENTS);
    else segs = seg_cnt_r;
    if (ring_cnt_r < RING_MIN) rings = RING_MIN;
    else if ({6'b0, ring_cnt_r} > 17'(MAX_RINGS)) rings = IW'(MAX_RINGS);
    else rings = ring_cnt_r;
  end

  // Advance the whole chain unless the output holds a stalled request
  assign en = !vld_r[LAT] || out_tready;
  assign in_tready = en;
  assign in_pt.ring = in_tdata[10:0];
  assign in_pt.seg  = in_tdata[21:11];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-1:1], in_tvalid};
    end
  end

  // Carry the grid point beside the datapath
  always_ff @(posedge clk) begin
    if (en) begin
      rs_r[1] <= in_pt;
      for (int k = 2; k <= S_E3; k++) rs_r[k] <= rs_r[k-1];
    end
  end

  // ---------------- modulo chain: seg mod segs, ring mod 2*rings ----------
  logic [1:0][DW-1:0] d_a;
  logic [1:0][DW-1:0] a_rem  [0:A_LEN];
  logic [1:0][IW-1:0] a_feed [0:A_LEN];
  logic [1:0][IW-1:0] a_q    [0:A_LEN-1];

  assign d_a[0] = {1'b0, segs};
  assign d_a[1] = {rings, 1'b0};
  assign a_rem[0]     = '0;
  assign a_feed[0][0] = in_pt.seg;
  assign a_feed[0][1] = in_pt.ring;
  assign a_q[0]       = '0;

  for (genvar k = 0; k < A_LEN; k++) begin : g_mod
    if (k == A_LEN - 1) begin : g_last
      uvs_div_cell #(.LANES(2), .QW(IW)) u_cell (
        .clk(clk), .en(en), .d_i(d_a), .rem_i(a_rem[k]), .feed_i(a_feed[k]),
        .q_i(a_q[k]), .rem_o(a_rem[k+1]), .feed_o(a_feed[k+1]), .q_o()
      );
    end else begin : g_mid
      uvs_div_cell #(.LANES(2), .QW(IW)) u_cell (
        .clk(clk), .en(en), .d_i(d_a), .rem_i(a_rem[k]), .feed_i(a_feed[k]),
        .q_i(a_q[k]), .rem_o(a_rem[k+1]), .feed_o(a_feed[k+1]), .q_o(a_q[k+1])
      );
    end
  end

  // ---------------- phase and texture chain -------------------------------
  // Lanes: theta phase, phi phase, tex_u, tex_v
  logic [NPH-1:0][DW-1:0] d_b;
  logic [NPH-1:0][DW-1:0] b_rem  [0:B_LEN];
  logic [NPH-1:0][PW-1:0] b_feed [0:B_LEN];
  logic [NPH-1:0][PW-1:0] b_q    [0:B_LEN];

  assign d_b[0] = {1'b0, segs};
  assign d_b[1] = {rings, 1'b0};
  assign d_b[2] = {1'b0, segs};
  assign d_b[3] = {1'b0, rings};

  // Seed each lane with its remainder and rounding half-divisor
  always_comb begin
    b_rem[0][0]  = a_rem[A_LEN][0];
    b_rem[0][1]  = a_rem[A_LEN][1];
    b_rem[0][2]  = (rs_r[A_LEN].seg < segs) ? {1'b0, rs_r[A_LEN].seg} : '0;
    b_rem[0][3]  = (rs_r[A_LEN].ring < rings) ? {1'b0, rs_r[A_LEN].ring} : '0;
    b_feed[0][0] = {22'b0, segs[IW-1:1]};
    b_feed[0][1] = {21'b0, rings};
    b_feed[0][2] = {6'b0, segs[IW-1:1], 16'b0};
    b_feed[0][3] = {6'b0, rings[IW-1:1], 16'b0};
    b_q[0]       = '0;
  end

  for (genvar k = 0; k < B_LEN; k++) begin : g_phase
    uvs_div_cell #(.LANES(NPH), .QW(PW)) u_cell (
      .clk(clk), .en(en), .d_i(d_b), .rem_i(b_rem[k]), .feed_i(b_feed[k]),
      .q_i(b_q[k]), .rem_o(b_rem[k+1]), .feed_o(b_feed[k+1]), .q_o(b_q[k+1])
    );
  end

  // ---------------- quadrant fold and texture saturation ------------------
  // Sine lanes: sin theta, cos theta, sin phi, cos phi
  logic [NPH-1:0][PW-1:0] phase;
  logic [NPH-1:0][XW-1:0] x_fold;
  logic [16:0]            tex_u_e;
  logic [16:0]            tex_v_e;
  logic [NPH-1:0][XW-1:0] e0_x_r;
  logic [NPH-1:0]         ng_r [S_E0:S_H_END];
  logic [16:0]            tu_r [S_E0:S_E3];
  logic [16:0]            tv_r [S_E0:S_E3];

  always_comb begin
    phase[0] = b_q[B_LEN][0];
    phase[1] = b_q[B_LEN][0] + Q30_ONE;
    phase[2] = b_q[B_LEN][1];
    phase[3] = b_q[B_LEN][1] + Q30_ONE;
    for (int l = 0; l < NPH; l++) begin
      x_fold[l] = phase[l][30] ? (Q30_ONE_X - {1'b0, phase[l][29:0]})
                               : {1'b0, phase[l][29:0]};
    end
    tex_u_e = (rs_r[S_B_END].seg >= segs) ? TEX_ONE : {1'b0, b_q[B_LEN][2][31:16]};
    tex_v_e = (rs_r[S_B_END].ring >= rings) ? TEX_ONE : {1'b0, b_q[B_LEN][3][31:16]};
  end

  // ---------------- square of the argument ---------------------------------
  logic [NPH-1:0][2*XW-1:0] xx;
  logic [NPH-1:0][XW-1:0]   e1_y_r;
  logic [NPH-1:0][XW-1:0]   e1_x_r;

  always_comb begin
    for (int l = 0; l < NPH; l++) begin
      xx[l] = {{XW{1'b0}}, e0_x_r[l]} * {{XW{1'b0}}, e0_x_r[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_x_r <= x_fold;
      ng_r[S_E0] <= {phase[3][31], phase[2][31], phase[1][31], phase[0][31]};
      for (int k = S_E0 + 1; k <= S_H_END; k++) ng_r[k] <= ng_r[k-1];
      tu_r[S_E0] <= tex_u_e;
      tv_r[S_E0] <= tex_v_e;
      for (int k = S_E0 + 1; k <= S_E3; k++) begin
        tu_r[k] <= tu_r[k-1];
        tv_r[k] <= tv_r[k-1];
      end
      for (int l = 0; l < NPH; l++) e1_y_r[l] <= xx[l][XW+29:30];
      e1_x_r <= e0_x_r;
    end
  end

  // ---------------- Horner chain -------------------------------------------
  logic [NPH-1:0][SW-1:0] h_s [0:HN];
  logic [NPH-1:0][XW-1:0] h_y [0:HN];
  logic [NPH-1:0][XW-1:0] h_x [0:HN];

  assign h_s[0] = {NPH{K11}};
  assign h_y[0] = e1_y_r;
  assign h_x[0] = e1_x_r;

  for (genvar k = 0; k < HN; k++) begin : g_horner
    uvs_horner_cell #(.COEF(HCOEF[k])) u_cell (
      .clk(clk), .en(en), .s_i(h_s[k]), .y_i(h_y[k]), .x_i(h_x[k]),
      .s_o(h_s[k+1]), .y_o(h_y[k+1]), .x_o(h_x[k+1])
    );
  end

  // ---------------- final multiply, limit and sign -------------------------
  logic [NPH-1:0][SW+XW-1:0] sx;
  logic [NPH-1:0][SW:0]      sx_sh;
  logic [NPH-1:0][XW-1:0]    mag_e2;
  logic [NPH-1:0][XW-1:0]    e2_m_r;
  logic [NPH-1:0]            e2_n_r;

  always_comb begin
    for (int l = 0; l < NPH; l++) begin
      sx[l]     = {{XW{1'b0}}, h_s[HN][l]} * {{SW{1'b0}}, h_x[HN][l]};
      sx_sh[l]  = sx[l][SW+XW-1:30];
      mag_e2[l] = (sx_sh[l] > {2'b0, Q30_ONE_X}) ? Q30_ONE_X : sx_sh[l][XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_m_r <= mag_e2;
      for (int l = 0; l < NPH; l++) e2_n_r[l] <= ng_r[S_H_END][l] && (mag_e2[l] != '0);
    end
  end

  // ---------------- direction products -------------------------------------
  logic [2*XW-1:0] px;
  logic [2*XW-1:0] pz;
  logic [XW-1:0]   vx_m;
  logic [XW-1:0]   vz_m;
  logic [XW-1:0]   e3_xm_r;
  logic [XW-1:0]   e3_zm_r;
  logic [XW-1:0]   e3_ym_r;
  logic            e3_xn_r;
  logic            e3_zn_r;
  logic            e3_yn_r;

  always_comb begin
    px   = {{XW{1'b0}}, e2_m_r[2]} * {{XW{1'b0}}, e2_m_r[1]} + 62'h2000_0000;
    pz   = {{XW{1'b0}}, e2_m_r[2]} * {{XW{1'b0}}, e2_m_r[0]} + 62'h2000_0000;
    vx_m = px[XW+29:30];
    vz_m = pz[XW+29:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e3_xm_r <= vx_m;
      e3_zm_r <= vz_m;
      e3_ym_r <= e2_m_r[3];
      e3_xn_r <= (e2_n_r[2] != e2_n_r[1]) && (vx_m != '0);
      e3_zn_r <= (e2_n_r[2] != e2_n_r[0]) && (vz_m != '0);
      e3_yn_r <= e2_n_r[3];
    end
  end

  // ---------------- scaling, indices and flags -----------------------------
  function automatic logic [24:0] to_pos(input logic neg, input logic [XW-1:0] m,
                                         input logic [23:0] rad);
    logic [54:0] p;
    logic [24:0] q;
    p = {31'b0, rad} * {24'b0, m} + 55'h2000_0000;
    q = p[54:30];
    return (neg && q != '0) ? 25'(-q) : q;
  endfunction

  function automatic logic [15:0] to_norm(input logic neg, input logic [XW-1:0] m);
    logic [XW:0] t;
    logic [15:0] q;
    t = {1'b0, m} + 32'h4000;
    q = (t[XW:15] > {1'b0, NORM_MAX}) ? NORM_MAX : t[30:15];
    return (neg && q != '0) ? 16'(-q) : q;
  endfunction

  grid_pt_t      pt_e4;
  logic [22:0]   row_prod;
  logic [20:0]   base_e4;
  logic [24:0]   pos_x_r;
  logic [24:0]   pos_y_r;
  logic [24:0]   pos_z_r;
  logic [15:0]   norm_x_r;
  logic [15:0]   norm_y_r;
  logic [15:0]   norm_z_r;
  logic [16:0]   tex_u_r;
  logic [16:0]   tex_v_r;
  logic [20:0]   base_r;
  logic [20:0]   below_r;
  logic          has_quad_r;
  logic          out_of_grid_r;

  always_comb begin
    pt_e4    = rs_r[S_E3];
    row_prod = {1'b0, pt_e4.ring} * ({1'b0, segs} + 12'd1);
    base_e4  = row_prod[20:0] + {10'b0, pt_e4.seg};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x_r       <= to_pos(e3_xn_r, e3_xm_r, radius_r);
      pos_y_r       <= to_pos(e3_yn_r, e3_ym_r, radius_r);
      pos_z_r       <= to_pos(e3_zn_r, e3_zm_r, radius_r);
      norm_x_r      <= to_norm(e3_xn_r, e3_xm_r);
      norm_y_r      <= to_norm(e3_yn_r, e3_ym_r);
      norm_z_r      <= to_norm(e3_zn_r, e3_zm_r);
      tex_u_r       <= tu_r[S_E3];
      tex_v_r       <= tv_r[S_E3];
      base_r        <= base_e4;
      below_r       <= base_e4 + {10'b0, segs} + 21'd1;
      has_quad_r    <= (pt_e4.ring < rings) && (pt_e4.seg < segs);
      out_of_grid_r <= (pt_e4.ring > rings) || (pt_e4.seg > segs);
    end
  end

  assign out_tvalid = vld_r[LAT];
  assign out_tdata  = {1'b0, below_r, base_r, tex_v_r, tex_u_r, norm_z_r, norm_y_r,
                       norm_x_r, pos_z_r, pos_y_r, pos_x_r};
  assign out_tuser  = {out_of_grid_r, has_quad_r};

  // ---------------- assertions ---------------------------------------------
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted request did not enter the chain");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("chain moved while output stalled");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(has_quad_r && out_of_grid_r))
    else $error("quad flagged for a point outside the grid");

  a_tex_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (tex_u_r <= TEX_ONE) && (tex_v_r <= TEX_ONE))
    else $error("texture coordinate above one");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (norm_x_r != 16'h8000) && (norm_y_r != 16'h8000)
                   && (norm_z_r != 16'h8000))
    else $error("normal component out of range");

endmodule

`default_nettype wire

FILE: tb/uv_sphere_vertex_generator_core_tb.sv
// Self-checking testbench for the UV sphere vertex generator core.
`default_nettype none

module uv_sphere_vertex_generator_core_tb;
  import uvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 53;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [63:0] Q30 = 64'd1073741824;

  typedef struct packed {
    logic [24:0] pos_x, pos_y, pos_z;
    logic [15:0] norm_x, norm_y, norm_z;
    logic [16:0] tex_u, tex_v;
    logic [20:0] base_vertex, below_vertex;
    logic        has_quad, out_of_grid;
  } vertex_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [23:0] data;
    logic        wait_idle;
  } stim_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [23:0] in_tdata;
  logic [199:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;

  uv_sphere_vertex_generator_core dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Predictor copy of the registers
  logic [23:0] radius_q;
  logic [10:0] seg_cnt_q, ring_cnt_q;

  stim_t   pending_q[$];
  vertex_t vertex_q[$];
  int      fail_count = 0;
  bit      stim_done = 0;
  bit      quiet = 0;
  longint  cycle_count = 0;

  function automatic logic [63:0] quarter_sine(logic [63:0] x);
    logic [63:0] y, s;
    y = (x * x) >> 30;
    s = 64'd3864;
    s = 64'd172272 - ((s * y) >> 30);
    s = 64'd5026986 - ((s * y) >> 30);
    s = 64'd85569306 - ((s * y) >> 30);
    s = 64'd693598668 - ((s * y) >> 30);
    s = 64'd1686629713 - ((s * y) >> 30);
    s = (s * x) >> 30;
    return (s > Q30) ? Q30 : s;
  endfunction

  function automatic logic [31:0] turn_phase(logic [63:0] n, logic [63:0] d);
    logic [63:0] t;
    t = ((n << 32) + (d >> 1)) / d;
    return t[31:0];
  endfunction

  // Sign in bit 63, Q30 magnitude below
  function automatic logic [63:0] phase_sine(logic [31:0] p);
    logic [63:0] r, x, m;
    r = {34'd0, p[29:0]};
    x = p[30] ? (Q30 - r) : r;
    m = quarter_sine(x);
    return {p[31] && m != 0, m[62:0]};
  endfunction

  function automatic logic [63:0] sm_product(logic [63:0] a, logic [63:0] b);
    logic [63:0] m;
    m = ({1'b0, a[62:0]} * {1'b0, b[62:0]} + (64'd1 << 29)) >> 30;
    return {(a[63] != b[63]) && m != 0, m[62:0]};
  endfunction

  function automatic logic [24:0] scale_pos(logic [63:0] v);
    logic [63:0] m;
    m = ({40'd0, radius_q} * {1'b0, v[62:0]} + (64'd1 << 29)) >> 30;
    return (v[63] && m != 0) ? (25'd0 - m[24:0]) : m[24:0];
  endfunction

  function automatic logic [15:0] scale_norm(logic [63:0] v);
    logic [63:0] m;
    m = ({1'b0, v[62:0]} + (64'd1 << 14)) >> 15;
    if (m > 64'd32767) m = 64'd32767;
    return (v[63] && m != 0) ? (16'd0 - m[15:0]) : m[15:0];
  endfunction

  function automatic logic [16:0] tex_ratio(logic [63:0] n, logic [63:0] d);
    logic [63:0] t;
    t = (n * 64'd65536 + (d >> 1)) / d;
    return (t > 64'd65536) ? 17'h10000 : t[16:0];
  endfunction

  function automatic vertex_t grid_vertex(logic [10:0] ring, logic [10:0] seg);
    logic [63:0] segs, rings, sphi, cphi, sth, cth, vx, vz, base;
    vertex_t v;
    segs = seg_cnt_q;
    rings = ring_cnt_q;
    if (segs < 3) segs = 3;
    if (segs > 1024) segs = 1024;
    if (rings < 2) rings = 2;
    if (rings > 1024) rings = 1024;
    sphi = phase_sine(turn_phase(ring, 2 * rings));
    cphi = phase_sine(turn_phase(ring, 2 * rings) + Q30_ONE);
    sth = phase_sine(turn_phase(seg, segs));
    cth = phase_sine(turn_phase(seg, segs) + Q30_ONE);
    vx = sm_product(sphi, cth);
    vz = sm_product(sphi, sth);
    v.pos_x = scale_pos(vx);
    v.pos_y = scale_pos(cphi);
    v.pos_z = scale_pos(vz);
    v.norm_x = scale_norm(vx);
    v.norm_y = scale_norm(cphi);
    v.norm_z = scale_norm(vz);
    v.tex_u = tex_ratio(seg, segs);
    v.tex_v = tex_ratio(ring, rings);
    base = ring * (segs + 1) + seg;
    v.base_vertex = base[20:0];
    v.below_vertex = base[20:0] + segs[20:0] + 21'd1;
    v.has_quad = (ring < rings) && (seg < segs);
    v.out_of_grid = (ring > rings) || (seg > segs);
    return v;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Driver: present pending requests at the falling edge
  int  idle_left = 0;
  int  hold_left = 0;
  bit  in_busy = 0, cfg_busy = 0;
  // Handshakes seen at the last rising edge
  bit  in_fire = 0, cfg_fire = 0;
  always @(negedge clk) begin
    stim_t s;
    if (!rst_n) begin
      in_tvalid <= 0;
      cfg_valid <= 0;
    end else begin
      if (in_busy && in_fire) in_busy = 0;
      if (cfg_busy && cfg_fire) cfg_busy = 0;
      if (!in_busy && !cfg_busy) begin
        if (idle_left > 0) begin
          idle_left--;
          in_tvalid <= 0;
          cfg_valid <= 0;
        end else if (pending_q.size() > 0) begin
          s = pending_q[0];
          if (s.is_cfg || s.wait_idle) begin
            in_tvalid <= 0;
            if (vertex_q.size() != 0) hold_left = LATENCY + 4;
            else if (hold_left > 0) hold_left--;
            else begin
              void'(pending_q.pop_front());
              if (s.is_cfg) begin
                cfg_valid <= 1;
                cfg_index <= s.idx;
                cfg_data <= s.data;
                cfg_busy = 1;
              end
            end
          end else begin
            void'(pending_q.pop_front());
            cfg_valid <= 0;
            in_tvalid <= 1;
            in_tdata <= s.data;
            in_busy = 1;
            if (!quiet && $urandom_range(0, 9) == 0) idle_left = $urandom_range(1, 5);
          end
        end else begin
          in_tvalid <= 0;
          cfg_valid <= 0;
          stim_done = 1;
        end
      end
    end
  end

  // Receiver backpressure in random bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n || quiet) out_tready <= 1;
    else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 0;
    end else out_tready <= 1;
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    vertex_t got, exp_v;
    if (rst_n) begin
      cycle_count++;
      in_fire = in_tvalid && in_tready;
      cfg_fire = cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_RADIUS:   radius_q = cfg_data;
          CFG_SEGMENTS: seg_cnt_q = cfg_data[10:0];
          CFG_RINGS:    ring_cnt_q = cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.pos_x = out_tdata[24:0];
        got.pos_y = out_tdata[49:25];
        got.pos_z = out_tdata[74:50];
        got.norm_x = out_tdata[90:75];
        got.norm_y = out_tdata[106:91];
        got.norm_z = out_tdata[122:107];
        got.tex_u = out_tdata[139:123];
        got.tex_v = out_tdata[156:140];
        got.base_vertex = out_tdata[177:157];
        got.below_vertex = out_tdata[198:178];
        got.has_quad = out_tuser[0];
        got.out_of_grid = out_tuser[1];
        if (vertex_q.size() == 0) begin
          $error("unexpected result %h", out_tdata);
          fail_count++;
        end else begin
          exp_v = vertex_q.pop_front();
          if (got.pos_x !== exp_v.pos_x) begin
            $error("pos_x exp %h got %h", exp_v.pos_x, got.pos_x); fail_count++; end
          if (got.pos_y !== exp_v.pos_y) begin
            $error("pos_y exp %h got %h", exp_v.pos_y, got.pos_y); fail_count++; end
          if (got.pos_z !== exp_v.pos_z) begin
            $error("pos_z exp %h got %h", exp_v.pos_z, got.pos_z); fail_count++; end
          if (got.norm_x !== exp_v.norm_x) begin
            $error("norm_x exp %h got %h", exp_v.norm_x, got.norm_x); fail_count++; end
          if (got.norm_y !== exp_v.norm_y) begin
            $error("norm_y exp %h got %h", exp_v.norm_y, got.norm_y); fail_count++; end
          if (got.norm_z !== exp_v.norm_z) begin
            $error("norm_z exp %h got %h", exp_v.norm_z, got.norm_z); fail_count++; end
          if (got.tex_u !== exp_v.tex_u) begin
            $error("tex_u exp %h got %h", exp_v.tex_u, got.tex_u); fail_count++; end
          if (got.tex_v !== exp_v.tex_v) begin
            $error("tex_v exp %h got %h", exp_v.tex_v, got.tex_v); fail_count++; end
          if (got.base_vertex !== exp_v.base_vertex) begin
            $error("base_vertex exp %h got %h", exp_v.base_vertex, got.base_vertex);
            fail_count++; end
          if (got.below_vertex !== exp_v.below_vertex) begin
            $error("below_vertex exp %h got %h", exp_v.below_vertex, got.below_vertex);
            fail_count++; end
          if (got.has_quad !== exp_v.has_quad) begin
            $error("has_quad exp %b got %b", exp_v.has_quad, got.has_quad); fail_count++; end
          if (got.out_of_grid !== exp_v.out_of_grid) begin
            $error("out_of_grid exp %b got %b", exp_v.out_of_grid, got.out_of_grid);
            fail_count++; end
        end
      end
      if (in_tvalid && in_tready)
        vertex_q.push_back(grid_vertex(in_tdata[10:0], in_tdata[21:11]));
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic add_point(int ring, int seg);
    pending_q.push_back('{1'b0, 2'd0, {2'b00, seg[10:0], ring[10:0]}, 1'b0});
  endtask

  task automatic add_write(cfg_reg_t r, logic [23:0] v);
    pending_q.push_back('{1'b1, r, v, 1'b0});
  endtask

  // Random phase: mostly in-grid points, some out of grid and raw noise
  task automatic add_random(int n);
    int segs, rings, k;
    segs = (seg_cnt_q < 3) ? 3 : (seg_cnt_q > 1024 ? 1024 : seg_cnt_q);
    rings = (ring_cnt_q < 2) ? 2 : (ring_cnt_q > 1024 ? 1024 : ring_cnt_q);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 7) add_point($urandom_range(0, rings), $urandom_range(0, segs));
      else if (k < 9) add_point($urandom_range(0, 1024), $urandom_range(0, 1024));
      else add_point($urandom_range(0, 2047), $urandom_range(0, 2047));
    end
  endtask

  // Queue writes now, mirroring them locally to size the random range
  task automatic set_grid(logic [23:0] r, logic [10:0] s, logic [10:0] g);
    add_write(CFG_RADIUS, r);
    add_write(CFG_SEGMENTS, {13'd0, s});
    add_write(CFG_RINGS, {13'd0, g});
    seg_cnt_q = s;
    ring_cnt_q = g;
  endtask

  initial begin
    logic [10:0] s_plan, g_plan;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 1;
    cfg_valid = 0;
    cfg_index = CFG_RADIUS;
    cfg_data = 0;
    radius_q = 24'h010000;
    seg_cnt_q = 11'd16;
    ring_cnt_q = 11'd8;
    repeat (6) @(posedge clk);
    // Directed: reset grid, poles, seam, out of grid, index extremes
    add_point(0, 0); add_point(8, 16); add_point(4, 4); add_point(0, 16);
    add_point(9, 17); add_point(2047, 2047); add_point(1024, 0); add_point(3, 12);
    set_grid(24'hFFFFFF, 11'd0, 11'd0);
    add_point(0, 0); add_point(1, 1); add_point(2, 3); add_point(1, 2);
    add_point(2047, 0); add_point(0, 2047);
    set_grid(24'h000000, 11'd2047, 11'd2047);
    add_point(512, 512); add_point(1024, 1024); add_point(1023, 1023);
    add_point(1025, 1025); add_point(2047, 2047); add_point(0, 1);
    // Random: several settings
    for (int ph = 0; ph < 8; ph++) begin
      s_plan = (ph % 3 == 0) ? 11'($urandom_range(0, 40)) : 11'($urandom_range(0, 2047));
      g_plan = (ph % 3 == 1) ? 11'($urandom_range(0, 40)) : 11'($urandom_range(0, 2047));
      set_grid((ph == 3) ? 24'hFFFFFF : 24'($urandom), s_plan, g_plan);
      if (ph == 4) pending_q.push_back('{1'b0, 2'd0, 24'd0, 1'b1});
      add_random(225);
    end
    // Restore the reset values of the predictor before the run starts
    radius_q = 24'h010000;
    seg_cnt_q = 11'd16;
    ring_cnt_q = 11'd8;
    @(negedge clk);
    rst_n = 1;
    wait (pending_q.size() < 300);
    quiet = 1;
    wait (stim_done && vertex_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && vertex_q.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

FILE: uv_sphere_vertex_generator_core.f
sv/uvs_pkg.sv
sv/uvs_div_cell.sv
sv/uvs_horner_cell.sv
sv/uv_sphere_vertex_generator_core.sv
tb/uv_sphere_vertex_generator_core_tb.sv
